// File: design/generational_handle_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// Generational handle allocator assertion macros
// Shared property shorthands for the allocator checks.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define GHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define GHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/gha_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Sizes, operation and status codes, and shared types.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int unsigned Entries = 1024;
  localparam int unsigned GenBits = 8;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned CntW    = IdxW + 1;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POOL_FULL  = 2'd1,
    ST_INVALID    = 2'd2,
    ST_QUEUE_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic [IdxW-1:0]    idx;
    logic [GenBits-1:0] gen;
  } handle_t;

  typedef struct packed {
    logic               en;
    logic [IdxW-1:0]    addr;
    logic [GenBits-1:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic    push;
    logic    pop;
    handle_t data;
  } fq_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fq_stat_t;

endpackage

// File: design/gha_req_if.sv
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one operation and a handle per beat.
// ----------------------------------------------------------------------------
interface gha_req_if;

  logic                        valid;
  logic                        ready;
  logic [1:0]                  op;
  logic [gha_pkg::IdxW-1:0]    handle_index;
  logic [gha_pkg::GenBits-1:0] handle_generation;

  modport source (output valid, output op, output handle_index,
                  output handle_generation, input ready);
  modport sink   (input valid, input op, input handle_index,
                  input handle_generation, output ready);

endinterface

// File: design/gha_rsp_if.sv
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface gha_rsp_if;

  logic                        valid;
  logic                        ready;
  logic [gha_pkg::IdxW-1:0]    out_index;
  logic [gha_pkg::GenBits-1:0] out_generation;
  logic                        is_valid;
  logic [1:0]                  status;

  modport source (output valid, output out_index, output out_generation,
                  output is_valid, output status, input ready);
  modport sink   (input valid, input out_index, input out_generation,
                  input is_valid, input status, output ready);

endinterface

// File: design/gha_gen_table.sv
// ----------------------------------------------------------------------------
// Generation table
// One-write one-read memory with registered read and same-edge write bypass.
// ----------------------------------------------------------------------------
module gha_gen_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [gha_pkg::IdxW-1:0]    rd_addr_i,
  input  gha_pkg::tbl_wr_t            wr_i,
  output logic [gha_pkg::GenBits-1:0] rd_data_o
);

  logic [gha_pkg::GenBits-1:0] mem [gha_pkg::Entries];
  logic [gha_pkg::GenBits-1:0] rdata_q;
  logic [gha_pkg::GenBits-1:0] fwd_data_q;
  logic                        fwd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q    <= mem[rd_addr_i];
      fwd_data_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_hit_q <= wr_i.en && (wr_i.addr == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_hit_q ? fwd_data_q : rdata_q;

endmodule

// File: design/gha_free_queue.sv
// ----------------------------------------------------------------------------
// Free handle queue
// Circular FIFO of released handles; head entry is prefetched every cycle.
// ----------------------------------------------------------------------------
module gha_free_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gha_pkg::fq_ctrl_t ctrl_i,
  output gha_pkg::handle_t  head_o,
  output gha_pkg::fq_stat_t stat_o
);

  gha_pkg::handle_t             mem [gha_pkg::Entries];
  gha_pkg::handle_t             rdata_q;
  gha_pkg::handle_t             fwd_data_q;
  logic                         fwd_hit_q;
  logic [gha_pkg::IdxW-1:0]     head_q, head_d;
  logic [gha_pkg::IdxW-1:0]     tail_q, tail_d;
  logic [gha_pkg::CntW-1:0]     fill_q, fill_d;

  localparam logic [gha_pkg::IdxW-1:0] LastPos = gha_pkg::IdxW'(gha_pkg::Entries - 1);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == LastPos) ? '0 : head_q + 1'b1;
    end
    if (ctrl_i.push) begin
      tail_d = (tail_q == LastPos) ? '0 : tail_q + 1'b1;
    end
    priority if (ctrl_i.push && !ctrl_i.pop) begin
      fill_d = fill_q + 1'b1;
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      fill_d = fill_q - 1'b1;
    end else begin
      fill_d = fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      fill_q    <= '0;
      fwd_hit_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      fill_q    <= fill_d;
      fwd_hit_q <= ctrl_i.push && (tail_q == head_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_q] <= ctrl_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q    <= mem[head_d];
    fwd_data_q <= ctrl_i.data;
  end

  assign head_o       = fwd_hit_q ? fwd_data_q : rdata_q;
  assign stat_o.empty = (fill_q == '0);
  assign stat_o.full  = (fill_q == gha_pkg::CntW'(gha_pkg::Entries));

endmodule

// File: design/generational_handle_allocator_unit.sv
// ----------------------------------------------------------------------------
// Generational handle allocator
// Hands out index/generation handles, recycles removed ones, checks handles.
//
// req_i carries one operation per beat: create, remove or check, with a
// handle for remove and check. rsp_o returns exactly one beat per request:
// the created handle, the validity flag and a status code.
// A request beat lands in the request register, reads the generation table
// there and is resolved into the response register once that register is
// free or its beat is taken. While rsp_o does not stall, one request is
// taken every cycle; the generation table read port and the prefetched
// free-queue head set that rate, with same-edge write bypass on both.
// Reset empties the free queue and forgets all issued indices; memory
// contents are left as they are. When rsp_o stalls, the response register
// and the request register hold, and req_i.ready drops once the request
// register holds a beat, until the response beat is taken.
// ----------------------------------------------------------------------------
`include "generational_handle_allocator_unit_defines.svh"

module generational_handle_allocator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  gha_req_if.sink    req_i,
  gha_rsp_if.source  rsp_o
);

  logic                        s1_valid_q;
  logic [1:0]                  s1_op_q;
  logic [gha_pkg::IdxW-1:0]    s1_idx_q;
  logic [gha_pkg::GenBits-1:0] s1_gen_q;
  logic [gha_pkg::CntW-1:0]    issued_q;

  logic                        rsp_valid_q;
  logic [gha_pkg::IdxW-1:0]    out_index_q, out_index_d;
  logic [gha_pkg::GenBits-1:0] out_gen_q, out_gen_d;
  logic                        is_valid_q, is_valid_d;
  gha_pkg::status_e            status_q, status_d;

  logic                        req_fire;
  logic                        retire;
  logic                        handle_ok;
  logic                        new_issue;
  logic                        pool_avail;
  logic [gha_pkg::GenBits-1:0] tbl_rdata;
  gha_pkg::tbl_wr_t            tbl_wr;
  gha_pkg::fq_ctrl_t           fq_ctrl;
  gha_pkg::fq_stat_t           fq_stat;
  gha_pkg::handle_t            fq_head;

  assign retire      = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || retire;
  assign req_fire    = req_i.valid && req_i.ready;

  gha_gen_table u_gen_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (req_fire),
    .rd_addr_i (req_i.handle_index),
    .wr_i      (tbl_wr),
    .rd_data_o (tbl_rdata)
  );

  gha_free_queue u_free_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (fq_ctrl),
    .head_o (fq_head),
    .stat_o (fq_stat)
  );

  assign handle_ok  = ({1'b0, s1_idx_q} < issued_q) && (tbl_rdata == s1_gen_q);
  assign pool_avail = issued_q < gha_pkg::CntW'(gha_pkg::Entries);

  always_comb begin
    out_index_d  = '0;
    out_gen_d    = '0;
    is_valid_d   = 1'b0;
    status_d     = gha_pkg::ST_OK;
    new_issue    = 1'b0;
    fq_ctrl.push = 1'b0;
    fq_ctrl.pop  = 1'b0;
    fq_ctrl.data = '{idx: s1_idx_q, gen: s1_gen_q + 1'b1};
    unique case (s1_op_q)
      gha_pkg::OP_CREATE: begin
        priority if (!fq_stat.empty) begin
          out_index_d = fq_head.idx;
          out_gen_d   = fq_head.gen;
          fq_ctrl.pop = retire;
        end else if (pool_avail) begin
          out_index_d = issued_q[gha_pkg::IdxW-1:0];
          new_issue   = retire;
        end else begin
          status_d = gha_pkg::ST_POOL_FULL;
        end
      end
      gha_pkg::OP_REMOVE: begin
        is_valid_d = handle_ok;
        priority if (!handle_ok) begin
          status_d = gha_pkg::ST_INVALID;
        end else if (fq_stat.full) begin
          status_d = gha_pkg::ST_QUEUE_FULL;
        end else begin
          fq_ctrl.push = retire;
        end
      end
      gha_pkg::OP_CHECK: begin
        is_valid_d = handle_ok;
      end
      default: begin
        is_valid_d = 1'b0;
      end
    endcase
  end

  assign tbl_wr.en   = new_issue || fq_ctrl.push;
  assign tbl_wr.addr = new_issue ? issued_q[gha_pkg::IdxW-1:0] : s1_idx_q;
  assign tbl_wr.data = new_issue ? '0 : fq_ctrl.data.gen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      issued_q    <= '0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (retire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (new_issue) begin
        issued_q <= issued_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_op_q  <= req_i.op;
      s1_idx_q <= req_i.handle_index;
      s1_gen_q <= req_i.handle_generation;
    end
    if (retire) begin
      out_index_q <= out_index_d;
      out_gen_q   <= out_gen_d;
      is_valid_q  <= is_valid_d;
      status_q    <= status_d;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.out_index      = out_index_q;
  assign rsp_o.out_generation = out_gen_q;
  assign rsp_o.is_valid       = is_valid_q;
  assign rsp_o.status         = status_q;

  `GHA_ASSERT_IMP(a_issued_bound, new_issue, pool_avail, "issue past pool size")
  `GHA_ASSERT_IMP(a_no_push_full, fq_ctrl.push, !fq_stat.full, "push into full free queue")
  `GHA_ASSERT_IMP(a_no_pop_empty, fq_ctrl.pop, !fq_stat.empty, "pop from empty free queue")
  `GHA_ASSERT_NXT(a_retire_shows, retire, rsp_valid_q, "retired request left no response beat")

endmodule

// File: bench/generational_handle_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// Generational handle allocator testbench
// Drives create, remove and check beats into the allocator through the
// request channel and compares every response beat, field by field, with a
// behavioral model of the handle pool kept in the bench. Covers never-issued
// handles, stale generations, double removal, generation wrap, pool
// exhaustion and a full free queue, under several idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module generational_handle_allocator_unit_tb;

  localparam logic [1:0] OpReserved = 2'd3;
  localparam int unsigned RandomItems = 400;

  typedef struct {
    logic [gha_pkg::IdxW-1:0]    idx;
    logic [gha_pkg::GenBits-1:0] gen;
    logic                        valid;
    gha_pkg::status_e            status;
  } alloc_rsp_t;

  logic clk_i;
  logic rst_ni;

  gha_req_if req_bus ();
  gha_rsp_if rsp_bus ();

  generational_handle_allocator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  logic [gha_pkg::GenBits-1:0] slot_gen [gha_pkg::Entries];
  int unsigned                 issued_slots;
  gha_pkg::handle_t            recycled_q [$];
  alloc_rsp_t                  pending_rsp [$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned fail_count;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic alloc_rsp_t predict_handle_op(
      input logic [1:0] op,
      input logic [gha_pkg::IdxW-1:0] idx,
      input logic [gha_pkg::GenBits-1:0] gen);
    alloc_rsp_t                  r;
    logic                        live;
    gha_pkg::handle_t            h;
    logic [gha_pkg::GenBits-1:0] next_gen;
    r = '{idx: '0, gen: '0, valid: 1'b0, status: gha_pkg::ST_OK};
    live = (32'(idx) < issued_slots) && (slot_gen[idx] == gen);
    case (op)
      gha_pkg::OP_CREATE: begin
        if (recycled_q.size() > 0) begin
          h = recycled_q.pop_front();
          r.idx = h.idx;
          r.gen = h.gen;
        end else if (issued_slots < gha_pkg::Entries) begin
          r.idx = gha_pkg::IdxW'(issued_slots);
          slot_gen[issued_slots] = '0;
          issued_slots++;
        end else begin
          r.status = gha_pkg::ST_POOL_FULL;
        end
      end
      gha_pkg::OP_REMOVE: begin
        r.valid = live;
        if (!live) begin
          r.status = gha_pkg::ST_INVALID;
        end else if (recycled_q.size() >= gha_pkg::Entries) begin
          r.status = gha_pkg::ST_QUEUE_FULL;
        end else begin
          next_gen = gen + 1'b1;
          slot_gen[idx] = next_gen;
          h.idx = idx;
          h.gen = next_gen;
          recycled_q = {recycled_q, h};
        end
      end
      gha_pkg::OP_CHECK: begin
        r.valid = live;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [gha_pkg::IdxW-1:0] idx,
                           input logic [gha_pkg::GenBits-1:0] gen);
    alloc_rsp_t exp_rsp;
    while ($urandom_range(99) < idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid             <= 1'b1;
    req_bus.op                <= op;
    req_bus.handle_index      <= idx;
    req_bus.handle_generation <= gen;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    exp_rsp = predict_handle_op(op, idx, gen);
    pending_rsp = {pending_rsp, exp_rsp};
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_rsp.size() != 0);
  endtask

  function automatic logic [gha_pkg::IdxW-1:0] pick_issued_slot();
    return gha_pkg::IdxW'($urandom_range(issued_slots - 1));
  endfunction

  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    alloc_rsp_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response beat: index %0d gen %0d valid %0b status %0d",
                 $time, rsp_bus.out_index, rsp_bus.out_generation, rsp_bus.is_valid,
                 rsp_bus.status);
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_bus.out_index !== want.idx) begin
          $display("%0t: out_index expected %0d, actual %0d", $time, want.idx,
                   rsp_bus.out_index);
          fail_count++;
        end
        if (rsp_bus.out_generation !== want.gen) begin
          $display("%0t: out_generation expected %0d, actual %0d", $time, want.gen,
                   rsp_bus.out_generation);
          fail_count++;
        end
        if (rsp_bus.is_valid !== want.valid) begin
          $display("%0t: is_valid expected %0b, actual %0b", $time, want.valid,
                   rsp_bus.is_valid);
          fail_count++;
        end
        if (rsp_bus.status !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status,
                   rsp_bus.status);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_beat(gha_pkg::OP_CHECK, '0, '0);
    send_beat(gha_pkg::OP_CHECK, '1, '1);
    send_beat(gha_pkg::OP_REMOVE, '0, '0);
    send_beat(OpReserved, '1, '1);
    send_beat(gha_pkg::OP_CREATE, '1, '1);
    send_beat(gha_pkg::OP_CREATE, '0, '0);
    send_beat(gha_pkg::OP_CHECK, '0, '0);
    send_beat(gha_pkg::OP_CHECK, '0, '1);
    send_beat(gha_pkg::OP_CHECK, gha_pkg::IdxW'(1), '0);
    send_beat(gha_pkg::OP_CHECK, gha_pkg::IdxW'(2), '0);
    send_beat(gha_pkg::OP_REMOVE, gha_pkg::IdxW'(1), '1);
    send_beat(gha_pkg::OP_REMOVE, '0, '0);
    send_beat(gha_pkg::OP_CHECK, '0, '0);
    send_beat(gha_pkg::OP_REMOVE, '0, gha_pkg::GenBits'(1));
    send_beat(gha_pkg::OP_CHECK, '0, gha_pkg::GenBits'(2));
    send_beat(gha_pkg::OP_CREATE, '0, '0);
    send_beat(gha_pkg::OP_CREATE, '0, '0);
    send_beat(gha_pkg::OP_CREATE, '0, '0);
    send_beat(gha_pkg::OP_CHECK, '0, gha_pkg::GenBits'(2));
    send_beat(gha_pkg::OP_REMOVE, '1, '1);
    send_beat(OpReserved, '0, '0);
  endtask

  task automatic test_generation_wrap();
    idle_pct  = 25;
    stall_pct = 25;
    for (int i = 0; i <= (1 << gha_pkg::GenBits); i++) begin
      send_beat(gha_pkg::OP_REMOVE, gha_pkg::IdxW'(1), slot_gen[1]);
    end
    send_beat(gha_pkg::OP_CHECK, gha_pkg::IdxW'(1), slot_gen[1]);
    send_beat(gha_pkg::OP_CHECK, gha_pkg::IdxW'(1),
              gha_pkg::GenBits'(slot_gen[1] - 1'b1));
  endtask

  task automatic test_random_traffic(input int unsigned n, input int unsigned idle,
                                     input int unsigned stall);
    int unsigned                 roll;
    logic [gha_pkg::IdxW-1:0]    idx;
    logic [gha_pkg::GenBits-1:0] gen;
    idle_pct  = idle;
    stall_pct = stall;
    for (int unsigned k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      idx  = gha_pkg::IdxW'($urandom);
      gen  = gha_pkg::GenBits'($urandom);
      if (roll < 35 || issued_slots == 0) begin
        send_beat(gha_pkg::OP_CREATE, idx, gen);
      end else if (roll < 60) begin
        idx = pick_issued_slot();
        send_beat(gha_pkg::OP_REMOVE, idx, slot_gen[idx]);
      end else if (roll < 68) begin
        send_beat(gha_pkg::OP_REMOVE, idx, gen);
      end else if (roll < 82) begin
        idx = pick_issued_slot();
        send_beat(gha_pkg::OP_CHECK, idx, slot_gen[idx]);
      end else if (roll < 90) begin
        idx = pick_issued_slot();
        send_beat(gha_pkg::OP_CHECK, idx,
                  gha_pkg::GenBits'(slot_gen[idx] + ($urandom_range(1) ? 1 : -1)));
      end else if (roll < 96) begin
        send_beat(gha_pkg::OP_CHECK, idx, gen);
      end else begin
        send_beat(OpReserved, idx, gen);
      end
    end
  endtask

  task automatic test_pool_exhaustion();
    idle_pct  = 25;
    stall_pct = 25;
    while (issued_slots < gha_pkg::Entries || recycled_q.size() > 0) begin
      send_beat(gha_pkg::OP_CREATE, gha_pkg::IdxW'($urandom), gha_pkg::GenBits'($urandom));
    end
    send_beat(gha_pkg::OP_CREATE, '0, '0);
    send_beat(gha_pkg::OP_CREATE, '1, '1);
  endtask

  task automatic test_free_queue_full();
    idle_pct  = 0;
    stall_pct = 25;
    for (int i = 0; recycled_q.size() < gha_pkg::Entries; i++) begin
      send_beat(gha_pkg::OP_REMOVE, gha_pkg::IdxW'(i), slot_gen[i]);
    end
    send_beat(gha_pkg::OP_REMOVE, '0, slot_gen[0]);
    send_beat(gha_pkg::OP_REMOVE, '1, slot_gen[gha_pkg::Entries-1]);
    send_beat(gha_pkg::OP_REMOVE, gha_pkg::IdxW'(1), gha_pkg::GenBits'(slot_gen[1] + 1'b1));
    send_beat(gha_pkg::OP_CHECK, gha_pkg::IdxW'(2), slot_gen[2]);
    for (int i = 0; i < 8; i++) begin
      send_beat(gha_pkg::OP_CREATE, '0, '0);
    end
    send_beat(gha_pkg::OP_REMOVE, gha_pkg::IdxW'(3), slot_gen[3]);
  endtask

  initial begin
    rst_ni                    = 1'b0;
    req_bus.valid            <= 1'b0;
    req_bus.op               <= gha_pkg::OP_CREATE;
    req_bus.handle_index     <= '0;
    req_bus.handle_generation <= '0;
    issued_slots              = 0;
    fail_count                = 0;
    idle_pct                  = 0;
    stall_pct                 = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(RandomItems / 4, 0, 0);
    test_random_traffic(RandomItems / 4, 58, 0);
    wait_drained();
    test_random_traffic(RandomItems / 4, 0, 58);
    test_random_traffic(RandomItems / 4, 25, 25);
    test_pool_exhaustion();
    test_generation_wrap();
    test_free_queue_full();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
